// ===== hw/rtl/glcd_pkg.sv =====
package glcd_pkg;

  // Controller commands sent in the frame header.
  localparam logic [7:0] CMD_ROW_SET = 8'h2B;
  localparam logic [7:0] CMD_COL_SET = 8'h2A;
  localparam logic [7:0] CMD_WRITE   = 8'h2C;

  // Configuration register indexes.
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic [9:0] FRAME_WIDTH_RESET  = 10'd180;
  localparam logic [9:0] FRAME_HEIGHT_RESET = 10'd128;

  // Header word positions.
  localparam logic [3:0] HDR_ROW_CMD   = 4'd0;
  localparam logic [3:0] HDR_ROW_Z0    = 4'd1;
  localparam logic [3:0] HDR_ROW_Z1    = 4'd2;
  localparam logic [3:0] HDR_ROW_HI    = 4'd3;
  localparam logic [3:0] HDR_ROW_LO    = 4'd4;
  localparam logic [3:0] HDR_COL_CMD   = 4'd5;
  localparam logic [3:0] HDR_COL_Z0    = 4'd6;
  localparam logic [3:0] HDR_COL_Z1    = 4'd7;
  localparam logic [3:0] HDR_COL_HI    = 4'd8;
  localparam logic [3:0] HDR_COL_LO    = 4'd9;
  localparam logic [3:0] HDR_WRITE_CMD = 4'd10;

  // Reciprocal of three for a 10-bit dividend: (x * 683) >> 11.
  localparam logic [9:0] RECIP_THREE = 10'd683;
  localparam int         RECIP_SHIFT = 11;

  // Two-bit gray level to controller code.
  localparam logic [2:0] GRAY_CODE [4] = '{3'd7, 3'd4, 3'd2, 3'd0};

  typedef struct packed {
    logic [1:0] group_position;
    logic [7:0] partial_byte;
    logic [9:0] column_count;
    logic [9:0] row_count;
  } pack_state_t;

  typedef struct packed {
    logic        emit;
    logic        frame_end;
    logic [7:0]  pixel_byte;
    pack_state_t next;
  } pack_result_t;

endpackage

// ===== hw/rtl/glcd_pixel_if.sv =====
interface glcd_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] gray_pixel;

  modport source (output valid, output gray_pixel, input ready);
  modport sink   (input valid, input gray_pixel, output ready);
endinterface

// ===== hw/rtl/glcd_byte_if.sv =====
interface glcd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_command;
  logic       ends_transfer;
  logic       last_of_run;

  modport source (output valid, output out_byte, output is_command,
                  output ends_transfer, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input is_command,
                  input ends_transfer, input last_of_run, output ready);
endinterface

// ===== hw/rtl/glcd_pixel_core.sv =====
// Packs one pixel into the current group and advances the row and column counts.
module glcd_pixel_core (
  input  logic [7:0]                gray_pixel,
  input  logic [9:0]                frame_width,
  input  logic [9:0]                frame_height,
  input  glcd_pkg::pack_state_t     state,
  output glcd_pkg::pack_result_t    result
);

  logic [2:0]  code;
  logic [9:0]  width_eff;
  logic [9:0]  height_eff;
  logic [7:0]  packed_byte;
  logic        row_end;
  logic        frame_end;
  logic        emit;

  always_comb begin
    code       = glcd_pkg::GRAY_CODE[gray_pixel[7:6]];
    width_eff  = (frame_width == 10'd0) ? 10'd1 : frame_width;
    height_eff = (frame_height == 10'd0) ? 10'd1 : frame_height;

    case (state.group_position)
      2'd0:    packed_byte = {code, 5'd0};
      2'd1:    packed_byte = state.partial_byte | {3'd0, code, 2'd0};
      default: packed_byte = state.partial_byte | {6'd0, code[2:1]};
    endcase

    row_end   = ({1'b0, state.column_count} + 11'd1) >= {1'b0, width_eff};
    frame_end = row_end && (({1'b0, state.row_count} + 11'd1) >= {1'b0, height_eff});
    emit      = (state.group_position >= 2'd2) || row_end;

    result.emit       = emit;
    result.frame_end  = frame_end;
    result.pixel_byte = packed_byte;

    if (emit) begin
      result.next.partial_byte   = 8'd0;
      result.next.group_position = 2'd0;
    end else begin
      result.next.partial_byte   = packed_byte;
      result.next.group_position = state.group_position + 2'd1;
    end

    if (row_end) begin
      result.next.column_count = 10'd0;
      result.next.row_count    = frame_end ? 10'd0 : state.row_count + 10'd1;
    end else begin
      result.next.column_count = state.column_count + 10'd1;
      result.next.row_count    = state.row_count;
    end
  end

endmodule

// ===== hw/rtl/gray_lcd_three_pixel_packer.sv =====
// A pixel is accepted into the input register, and its byte word is then written to the output register.
// Throughput: one pixel per cycle while the output is not stalled and no header is going out.
// One byte word goes out per three pixels, or sooner at the end of a row. Once a frame,
// the first pixel stays in the input register and the input stalls while the eleven
// header words leave through the single output register, one word a cycle unless stalled.
// Reset is synchronous and active high: it clears all control state, drops the
// output valid and loads the frame width and height with 180 and 128.
module gray_lcd_three_pixel_packer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [9:0]  cfg_data,
  glcd_pixel_if.sink  pixel_stream,
  glcd_byte_if.source byte_stream
);

  // Configuration registers.
  logic [9:0] frame_width;
  logic [9:0] frame_height;

  // The input register holds one pixel until it has been worked on. While no frame is
  // open, the held pixel first waits for the whole header to go out.
  logic       hold_valid;
  logic [7:0] hold_pixel;
  logic       in_frame;
  logic [3:0] header_index;

  glcd_pkg::pack_state_t  pack_state;
  glcd_pkg::pack_result_t pack_result;

  // Output register, which parts the two sides of the block.
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_command;
  logic       out_ends;
  logic       out_last;

  logic       out_free;
  logic       header_go;
  logic       pixel_go;
  logic [8:0] width_third;
  logic [19:0] width_product;
  logic [7:0] header_byte;
  logic       header_command;
  logic       header_ends;
  logic       header_last;

  glcd_pixel_core u_core (
    .gray_pixel   (hold_pixel),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .state        (pack_state),
    .result       (pack_result)
  );

  always_comb begin
    out_free  = !out_valid || byte_stream.ready;
    header_go = hold_valid && !in_frame && out_free;
    // A pixel that completes no byte needs no room at the output.
    pixel_go  = hold_valid && in_frame && (out_free || !pack_result.emit);

    pixel_stream.ready = !hold_valid || pixel_go;

    // The column window is given in groups of three pixels, rounded down.
    width_product = frame_width * glcd_pkg::RECIP_THREE;
    width_third   = width_product[glcd_pkg::RECIP_SHIFT +: 9];

    header_command = 1'b0;
    header_ends    = 1'b0;
    case (header_index)
      glcd_pkg::HDR_ROW_CMD: begin
        header_byte    = glcd_pkg::CMD_ROW_SET;
        header_command = 1'b1;
      end
      glcd_pkg::HDR_ROW_HI:  header_byte = {6'd0, frame_height[9:8]};
      glcd_pkg::HDR_ROW_LO: begin
        header_byte = frame_height[7:0];
        header_ends = 1'b1;
      end
      glcd_pkg::HDR_COL_CMD: begin
        header_byte    = glcd_pkg::CMD_COL_SET;
        header_command = 1'b1;
      end
      glcd_pkg::HDR_COL_HI:  header_byte = {7'd0, width_third[8]};
      glcd_pkg::HDR_COL_LO: begin
        header_byte = width_third[7:0];
        header_ends = 1'b1;
      end
      glcd_pkg::HDR_WRITE_CMD: begin
        header_byte    = glcd_pkg::CMD_WRITE;
        header_command = 1'b1;
      end
      default: header_byte = 8'd0;
    endcase

    // The write command closes the run unless the frame is a single column wide, in
    // which case the held pixel completes a byte of its own straight after it.
    header_last = (header_index == glcd_pkg::HDR_WRITE_CMD) && (frame_width > 10'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= glcd_pkg::FRAME_WIDTH_RESET;
      frame_height <= glcd_pkg::FRAME_HEIGHT_RESET;
      hold_valid   <= 1'b0;
      in_frame     <= 1'b0;
      header_index <= glcd_pkg::HDR_ROW_CMD;
      pack_state   <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          glcd_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
          glcd_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
          default: ;
        endcase
      end

      if (pixel_stream.valid && pixel_stream.ready) begin
        hold_valid <= 1'b1;
      end else if (pixel_go) begin
        hold_valid <= 1'b0;
      end

      if (header_go) begin
        if (header_index == glcd_pkg::HDR_WRITE_CMD) begin
          header_index <= glcd_pkg::HDR_ROW_CMD;
          in_frame     <= 1'b1;
          pack_state   <= '0;
        end else begin
          header_index <= header_index + 4'd1;
        end
      end

      if (pixel_go) begin
        pack_state <= pack_result.next;
        if (pack_result.frame_end) begin
          in_frame <= 1'b0;
        end
      end

      if (out_free) begin
        out_valid <= header_go || (pixel_go && pack_result.emit);
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (pixel_stream.valid && pixel_stream.ready) begin
      hold_pixel <= pixel_stream.gray_pixel;
    end
    if (header_go) begin
      out_byte    <= header_byte;
      out_command <= header_command;
      out_ends    <= header_ends;
      out_last    <= header_last;
    end else if (pixel_go && pack_result.emit) begin
      out_byte    <= pack_result.pixel_byte;
      out_command <= 1'b0;
      out_ends    <= pack_result.frame_end;
      out_last    <= 1'b1;
    end
  end

  assign byte_stream.valid         = out_valid;
  assign byte_stream.out_byte      = out_byte;
  assign byte_stream.is_command    = out_command;
  assign byte_stream.ends_transfer = out_ends;
  assign byte_stream.last_of_run   = out_last;

endmodule

// ===== hw/rtl/glcd_checker.sv =====
module glcd_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       is_command,
  input logic       ends_transfer,
  input logic       last_of_run
);

  // A stalled word holds.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(is_command))
    else $error("stalled output word changed");

  // Reset empties the output register.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // A command word never releases chip select.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && is_command |-> !ends_transfer)
    else $error("command word ends a transfer");

  // The window commands are always followed by their data in the same run.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && is_command && (out_byte == 8'h2B || out_byte == 8'h2A) |-> !last_of_run)
    else $error("window command closes a run");

endmodule

bind gray_lcd_three_pixel_packer glcd_checker u_glcd_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (byte_stream.valid),
  .out_ready     (byte_stream.ready),
  .out_byte      (byte_stream.out_byte),
  .is_command    (byte_stream.is_command),
  .ends_transfer (byte_stream.ends_transfer),
  .last_of_run   (byte_stream.last_of_run)
);
